// ===== rtl/rhs_pkg.sv =====
// package: types, constants and helpers of the range hazard request sequencer
`timescale 1ns / 1ps
`default_nettype none
package rhs_pkg;

    localparam int INFLIGHT_DEPTH = 16;
    localparam int WAITING_DEPTH  = 16;
    localparam int ID_BITS        = 16;

    localparam int IF_IW = (INFLIGHT_DEPTH > 1) ? $clog2(INFLIGHT_DEPTH) : 1;
    localparam int WT_IW = (WAITING_DEPTH > 1) ? $clog2(WAITING_DEPTH) : 1;
    localparam int WT_CW = $clog2(WAITING_DEPTH + 1);

    typedef enum logic [0:0] {
        ACT_SUBMIT = 1'b0,
        ACT_FINISH = 1'b1
    } t_action;

    typedef enum logic [2:0] {
        ST_STARTED     = 3'd0,
        ST_QUEUED      = 3'd1,
        ST_REJECTED    = 3'd2,
        ST_FIN_NONE    = 3'd3,
        ST_FIN_STARTED = 3'd4,
        ST_UNKNOWN_ID  = 3'd5
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SUB,
        S_FIN,
        S_SCAN
    } t_state;

    typedef struct packed {
        logic        action;
        logic        is_read;
        logic [31:0] file_handle;
        logic [47:0] byte_offset;
        logic [31:0] byte_length;
        logic [15:0] finished_id;
    } t_in;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] request_id;
    } t_out;

    typedef struct packed {
        logic [ID_BITS-1:0] id;
        logic               rd;
        logic [31:0]        handle;
        logic [47:0]        offset;
        logic [31:0]        length;
    } t_req;

    // low 16 bits of an id, zero extended when ids are narrower
    function automatic logic [15:0] to_rid(input logic [ID_BITS-1:0] id);
        logic [ID_BITS+15:0] wide;
        wide = {16'd0, id};
        return wide[15:0];
    endfunction

    // id equals the 16-bit finish id after zero extension of both
    function automatic logic id_match(input logic [ID_BITS-1:0] id,
                                      input logic [15:0] fid);
        logic [ID_BITS+15:0] a;
        logic [ID_BITS+15:0] b;
        a = {16'd0, id};
        b = {{ID_BITS{1'b0}}, fid};
        return a == b;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/rhs_hazard.sv =====
// hazard checker: one request against every in-flight slot in parallel
`timescale 1ns / 1ps
`default_nettype none
module rhs_hazard
    import rhs_pkg::*;
(
    input  var t_req                      i_req,
    input  var t_req                      i_tab [INFLIGHT_DEPTH],
    input  wire logic [INFLIGHT_DEPTH-1:0] i_valid,
    output logic                          o_conflict
);

    logic [INFLIGHT_DEPTH-1:0] hit;

    always_comb begin
        logic [47:0] lo;
        logic [48:0] ea;
        logic [48:0] eb;
        logic [48:0] hi;
        for (int i = 0; i < INFLIGHT_DEPTH; i++) begin
            lo = (i_req.offset > i_tab[i].offset) ? i_req.offset : i_tab[i].offset;
            ea = {1'b0, i_req.offset} + {17'd0, i_req.length};
            eb = {1'b0, i_tab[i].offset} + {17'd0, i_tab[i].length};
            hi = (ea < eb) ? ea : eb;
            hit[i] = i_valid[i] && ({1'b0, lo} < hi)
                     && (i_req.handle == i_tab[i].handle)
                     && !(i_req.rd && i_tab[i].rd);
        end
    end

    assign o_conflict = |hit;

endmodule
`default_nettype wire

// ===== rtl/range_hazard_request_sequencer_core.sv =====
// top level: request sequencer with in-flight table, waiting list and control
`timescale 1ns / 1ps
`default_nettype none
// orders read and write requests on byte ranges of file handles. a submit takes
// the next id and starts at once when its range overlaps no in-flight request of
// the same handle (two reads never clash) and a slot is free, otherwise it joins
// the waiting list, or is rejected when that list is full. a finish frees its
// slot and then walks the waiting list oldest first, starting the first request
// that is now free of hazards. one transaction in gives exactly one transaction
// out. a submit or an unknown-id finish loads its result in its working state,
// S_SUB or S_FIN, the state right after acceptance, then returns to idle; a
// known finish frees its slot in S_FIN and then, in S_SCAN, passes over the
// waiting entries (at most WAITING_DEPTH) that cannot start, because the single
// hazard checker looks at one waiting entry per cycle against all in-flight
// slots. the input is stalled while a transaction is being worked on; a finished
// result waits in the output register, and the next transaction is taken
// meanwhile. a transaction whose result is ready while the output register is
// still stalled holds its state until the register is free. no clearing pass is
// needed after reset.
module range_hazard_request_sequencer_core
    import rhs_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_stall,
    input  var t_in   i_in_data,
    output logic      o_out_valid,
    input  wire logic i_out_stall,
    output t_out      o_out_data
);

    // control state
    t_state                    r_state;
    t_state                    n_state;
    logic [ID_BITS-1:0]        r_next_id;
    logic [WT_CW-1:0]          r_wcount;
    logic [WT_CW-1:0]          r_idx;
    logic [INFLIGHT_DEPTH-1:0] r_if_valid;
    logic                      r_out_valid;

    // payload
    t_req                      r_if_entry [INFLIGHT_DEPTH];
    t_req                      r_wt_entry [WAITING_DEPTH];
    t_req                      r_req;
    logic [15:0]               r_fid;
    t_out                      r_out_data;

    logic in_accept;
    logic out_free;
    logic out_set;
    logic conflict;
    t_req chk_req;

    // lowest free slot and lowest slot holding the finish id
    logic             free_found;
    logic [IF_IW-1:0] free_idx;
    logic             hit_found;
    logic [IF_IW-1:0] hit_idx;

    logic scan_end;
    logic scan_start;

    assign in_accept   = i_in_valid && !o_in_stall;
    assign o_in_stall  = (r_state != S_IDLE);
    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // shared hazard checker: the new submit, or the waiting entry under the scan
    assign chk_req = (r_state == S_SCAN) ? r_wt_entry[r_idx[WT_IW-1:0]] : r_req;

    rhs_hazard u_hazard (
        .i_req      (chk_req),
        .i_tab      (r_if_entry),
        .i_valid    (r_if_valid),
        .o_conflict (conflict)
    );

    always_comb begin
        free_found = 1'b0;
        free_idx   = '0;
        hit_found  = 1'b0;
        hit_idx    = '0;
        for (int i = INFLIGHT_DEPTH - 1; i >= 0; i--) begin
            if (!r_if_valid[i]) begin
                free_found = 1'b1;
                free_idx   = IF_IW'(i);
            end
            if (r_if_valid[i] && id_match(r_if_entry[i].id, r_fid)) begin
                hit_found = 1'b1;
                hit_idx   = IF_IW'(i);
            end
        end
    end

    // scan ends past the last waiting entry, or on a startable entry
    assign scan_end   = (r_idx >= r_wcount);
    assign scan_start = !scan_end && !conflict && free_found;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    n_state = (i_in_data.action == ACT_FINISH) ? S_FIN : S_SUB;
                end
            end
            S_SUB: begin
                if (out_free) n_state = S_IDLE;
            end
            S_FIN: begin
                if (!hit_found) begin
                    if (out_free) n_state = S_IDLE;
                end else begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if ((scan_end || scan_start) && out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // result load
    always_comb begin
        out_set = 1'b0;
        unique case (r_state)
            S_SUB:   out_set = out_free;
            S_FIN:   out_set = !hit_found && out_free;
            S_SCAN:  out_set = (scan_end || scan_start) && out_free;
            default: out_set = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_set) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // datapath and table updates
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_next_id   <= '0;
            r_wcount    <= '0;
            r_idx       <= '0;
            r_if_valid  <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (in_accept) begin
                        if (i_in_data.action == ACT_SUBMIT) begin
                            r_next_id <= r_next_id + 1'b1;
                        end
                        r_req.id     <= r_next_id + 1'b1;
                        r_req.rd     <= i_in_data.is_read;
                        r_req.handle <= i_in_data.file_handle;
                        r_req.offset <= i_in_data.byte_offset;
                        r_req.length <= i_in_data.byte_length;
                        r_fid        <= i_in_data.finished_id;
                    end
                end
                S_SUB: begin
                    if (out_free) begin
                        r_out_data.request_id <= to_rid(r_req.id);
                        if (free_found && !conflict) begin
                            r_if_entry[free_idx] <= r_req;
                            r_if_valid[free_idx] <= 1'b1;
                            r_out_data.status    <= ST_STARTED;
                        end else if (r_wcount < WT_CW'(WAITING_DEPTH)) begin
                            r_wt_entry[r_wcount[WT_IW-1:0]] <= r_req;
                            r_wcount             <= r_wcount + 1'b1;
                            r_out_data.status    <= ST_QUEUED;
                        end else begin
                            r_out_data.status    <= ST_REJECTED;
                        end
                    end
                end
                S_FIN: begin
                    r_idx <= '0;
                    if (hit_found) begin
                        r_if_valid[hit_idx] <= 1'b0;
                    end else if (out_free) begin
                        r_out_data.status     <= ST_UNKNOWN_ID;
                        r_out_data.request_id <= '0;
                    end
                end
                S_SCAN: begin
                    if (scan_end) begin
                        if (out_free) begin
                            r_out_data.status     <= ST_FIN_NONE;
                            r_out_data.request_id <= '0;
                        end
                    end else if (scan_start) begin
                        if (out_free) begin
                            r_if_entry[free_idx] <= chk_req;
                            r_if_valid[free_idx] <= 1'b1;
                            // close the gap, younger entries move up one place
                            for (int k = 0; k < WAITING_DEPTH - 1; k++) begin
                                if (WT_CW'(k) >= r_idx) r_wt_entry[k] <= r_wt_entry[k + 1];
                            end
                            r_wcount              <= r_wcount - 1'b1;
                            r_out_data.status     <= ST_FIN_STARTED;
                            r_out_data.request_id <= to_rid(chk_req.id);
                        end
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    // waiting list never overfills
    a_wcount_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wcount <= WT_CW'(WAITING_DEPTH))
        else $error("waiting count beyond depth");

    // an accepted transaction blocks the input on the next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> o_in_stall)
        else $error("input not stalled after acceptance");

    // a result appears only out of a working state
    a_result_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) != S_IDLE))
        else $error("result without work");

    // a started waiting request shrinks the list by exactly one
    a_scan_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN && scan_start && out_free) |=> (r_wcount == $past(r_wcount) - 1'b1))
        else $error("waiting list not popped");

endmodule
`default_nettype wire
